FILE: hdl/pointer_cursor_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pointer cursor tracker
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef POINTER_CURSOR_TRACKER_TOP_MACROS_SVH
`define POINTER_CURSOR_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define PCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pct: same-cycle check failed");

// implication checked in the next cycle
`define PCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pct: next-cycle check failed");

`endif

FILE: hdl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Types, constants and the clamp helper for the pointer cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  localparam int COORD_W  = 12;
  localparam int END_W    = 13;
  localparam int DELTA_W  = 9;
  localparam int SPEED_W  = 8;
  localparam int RUN_W    = 6;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 13;
  // delta * gain is 18 bits signed; one more for the fraction carry
  localparam int POOL_W   = 19;

  localparam logic [RUN_W-1:0]   RUN_LIMIT     = 6'd45;
  localparam logic [SPEED_W-1:0] SPEED_RESET   = 8'd64;
  localparam logic [COORD_W-1:0] COORD_MAX     = 12'd4095;

  typedef enum logic [IDX_W-1:0] {
    REG_STEP_SPEED       = 3'd0,
    REG_LIMIT_LEFT       = 3'd1,
    REG_LIMIT_TOP        = 3'd2,
    REG_LIMIT_RIGHT_END  = 3'd3,
    REG_LIMIT_BOTTOM_END = 3'd4
  } reg_index_t;

  typedef logic signed [POOL_W-1:0] pool_t;

  // upper clamp first, then lower: crossed limits resolve to the lower bound
  function automatic logic [COORD_W-1:0] clamp_axis(input pool_t v,
                                                    input logic [COORD_W-1:0] lo,
                                                    input logic [END_W-1:0] bound);
    pool_t hi;
    pool_t r;
    hi = $signed({{(POOL_W-END_W){1'b0}}, bound}) - pool_t'(1);
    if (hi > $signed({{(POOL_W-COORD_W){1'b0}}, COORD_MAX})) begin
      hi = $signed({{(POOL_W-COORD_W){1'b0}}, COORD_MAX});
    end
    r = v;
    if (r > hi) begin
      r = hi;
    end
    if (r < $signed({{(POOL_W-COORD_W){1'b0}}, lo})) begin
      r = $signed({{(POOL_W-COORD_W){1'b0}}, lo});
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pointer_cursor_tracker_top.sv
// ----------------------------------------------------------------------------
// pointer_cursor_tracker_top
// Scales mouse reports into a fractional position, clamps it to a limit
// rectangle and shows a midpoint-smoothed cursor until a long move run.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: delta_x, delta_y
//  m_*     | out | m_tvalid/m_tready  | tdata: cursor_x, cursor_y; tuser: smoothing_on
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One report per cycle sustained while m_tready is high; m_tvalid rises after
// the s_* transaction has passed the input register, then the multiply/accumulate/
// clamp/average pass into the result register, which also updates the position state.
// rst is synchronous: position to screen center, smoothing on, speed 64.
// A stalled output holds the result; the input register still takes one more
// transaction, then s_tready drops. cfg_ready is always high.
`default_nettype none

module pointer_cursor_tracker_top #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int FRACTION_BITS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [23:0]                   s_tdata,   // delta_x[8:0], delta_y[17:9], zero
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [23:0]                        m_tdata,   // cursor_x[11:0], cursor_y[23:12]
  output logic [0:0]                         m_tuser,   // smoothing_on[0]
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pct_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [pct_pkg::CFG_W-1:0]     cfg_data
);

  import pct_pkg::*;

  `include "pointer_cursor_tracker_top_macros.svh"

  localparam int FB = FRACTION_BITS;

  // configuration
  logic [SPEED_W-1:0] step_speed;
  logic [COORD_W-1:0] limit_left;
  logic [COORD_W-1:0] limit_top;
  logic [END_W-1:0]   limit_right_end;
  logic [END_W-1:0]   limit_bottom_end;

  // state
  logic [FB-1:0]      fraction_x;
  logic [FB-1:0]      fraction_y;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  logic               smooth_active;
  logic [RUN_W-1:0]   moving_run_count;

  // input register
  logic                      in_valid;
  logic signed [DELTA_W-1:0] in_dx;
  logic signed [DELTA_W-1:0] in_dy;

  // result register
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               out_smooth;

  logic advance;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // datapath
  logic signed [DELTA_W-1:0] gain;
  pool_t                     pool_x, pool_y;
  pool_t                     pos_x, pos_y;
  logic [COORD_W-1:0]        nx, ny;
  logic                      moved;
  logic [COORD_W:0]          sum_x, sum_y;
  logic [COORD_W-1:0]        shown_x_next, shown_y_next;
  logic [RUN_W-1:0]          run_next;
  logic                      smooth_next;

  always_comb begin
    // a speed of zero acts as one
    gain = (step_speed == '0) ? DELTA_W'(1) : $signed({1'b0, step_speed});
    pool_x = POOL_W'(in_dx * gain) + $signed({{(POOL_W-FB){1'b0}}, fraction_x});
    pool_y = POOL_W'(in_dy * gain) + $signed({{(POOL_W-FB){1'b0}}, fraction_y});
    pos_x = $signed({{(POOL_W-COORD_W){1'b0}}, target_x}) + (pool_x >>> FB);
    pos_y = $signed({{(POOL_W-COORD_W){1'b0}}, target_y}) + (pool_y >>> FB);
    nx = clamp_axis(pos_x, limit_left, limit_right_end);
    ny = clamp_axis(pos_y, limit_top, limit_bottom_end);
    moved = (nx != target_x) || (ny != target_y);
    sum_x = {1'b0, target_x} + {1'b0, nx};
    sum_y = {1'b0, target_y} + {1'b0, ny};

    shown_x_next = nx;
    shown_y_next = ny;
    run_next     = moving_run_count;
    smooth_next  = smooth_active;
    if (smooth_active) begin
      if (moved) begin
        shown_x_next = sum_x[COORD_W:1];
        shown_y_next = sum_y[COORD_W:1];
        if (moving_run_count <= RUN_LIMIT) begin
          run_next = moving_run_count + RUN_W'(1);
        end
        if (run_next > RUN_LIMIT) begin
          smooth_next = 1'b0;
        end
      end else begin
        run_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_speed       <= SPEED_RESET;
      limit_left       <= '0;
      limit_top        <= '0;
      limit_right_end  <= END_W'(SCREEN_WIDTH);
      limit_bottom_end <= END_W'(SCREEN_HEIGHT);
      fraction_x       <= '0;
      fraction_y       <= '0;
      target_x         <= COORD_W'(SCREEN_WIDTH / 2);
      target_y         <= COORD_W'(SCREEN_HEIGHT / 2);
      smooth_active    <= 1'b1;
      moving_run_count <= '0;
      in_valid         <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_dx    <= $signed(s_tdata[DELTA_W-1:0]);
        in_dy    <= $signed(s_tdata[2*DELTA_W-1:DELTA_W]);
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        fraction_x       <= pool_x[FB-1:0];
        fraction_y       <= pool_y[FB-1:0];
        target_x         <= nx;
        target_y         <= ny;
        smooth_active    <= smooth_next;
        moving_run_count <= run_next;
        out_x            <= shown_x_next;
        out_y            <= shown_y_next;
        out_smooth       <= smooth_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SPEED: begin
            step_speed <= cfg_data[SPEED_W-1:0];
            fraction_x <= '0;
            fraction_y <= '0;
          end
          REG_LIMIT_LEFT:       limit_left       <= cfg_data[COORD_W-1:0];
          REG_LIMIT_TOP:        limit_top        <= cfg_data[COORD_W-1:0];
          REG_LIMIT_RIGHT_END:  limit_right_end  <= cfg_data[END_W-1:0];
          REG_LIMIT_BOTTOM_END: limit_bottom_end <= cfg_data[END_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign m_tdata = {out_y, out_x};
  assign m_tuser = out_smooth;

  // smoothing never comes back once dropped
  `PCT_ASSERT_NEXT(a_smooth_sticky, !smooth_active, !smooth_active)
  // while smoothing, the run has not passed the limit
  `PCT_ASSERT_NOW(a_run_bound, smooth_active, moving_run_count <= RUN_LIMIT)
  // input side stalls only behind a held result
  `PCT_ASSERT_NOW(a_stall_cause, !s_tready, in_valid && m_tvalid && !m_tready)

endmodule

`default_nettype wire
